FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the track parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, masked during reset
`define CHK_IMPL(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, masked during reset
`define CHK_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

FILE: hw/rtl/mtp_pkg.sv
package mtp_pkg;

  localparam logic [31:0] MTRK_TAG  = 32'h4D54726B;
  localparam logic [25:0] TEMPO_NUM = 26'd60000000;
  localparam logic [17:0] FREQ_MAX  = 18'd200702;

  localparam logic [3:0] K_NOTE_OFF     = 4'd0;
  localparam logic [3:0] K_NOTE_ON      = 4'd1;
  localparam logic [3:0] K_TEMPO        = 4'd2;
  localparam logic [3:0] K_KEY          = 4'd3;
  localparam logic [3:0] K_TIME_SIG     = 4'd4;
  localparam logic [3:0] K_END          = 4'd5;
  localparam logic [3:0] K_SYSEX        = 4'd6;
  localparam logic [3:0] K_BAD_HEADER   = 4'd7;
  localparam logic [3:0] K_UNKNOWN_META = 4'd8;
  localparam logic [3:0] K_BAD_STATUS   = 4'd9;

  localparam logic [7:0] META_END   = 8'h2F;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_TSIG  = 8'h58;
  localparam logic [7:0] META_KEY   = 8'h59;

  // Byte-level datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_HDR, OP_DELTA, OP_STATUS, OP_DATA, OP_SKIP, OP_MTYPE, OP_MLEN, OP_SKLEN
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
    logic div_start;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0]  byte_v;
    logic [2:0]  hdr_cnt;
    logic        tag_ok;
    logic [27:0] count;
    logic [7:0]  status;
    logic [7:0]  mtype;
    logic        div_busy;
    logic        skip_zero;
  } dp_sts_t;

  // round(110 * 2^(r/12) * 2^20)
  function automatic logic [27:0] freq_tab(input logic [3:0] r);
    logic [27:0] v;
    unique case (r)
      4'd0:    v = 28'd115343360;
      4'd1:    v = 28'd122202033;
      4'd2:    v = 28'd129468544;
      4'd3:    v = 28'd137167144;
      4'd4:    v = 28'd145323527;
      4'd5:    v = 28'd153964914;
      4'd6:    v = 28'd163120144;
      4'd7:    v = 28'd172819773;
      4'd8:    v = 28'd183096171;
      4'd9:    v = 28'd193983646;
      4'd10:   v = 28'd205518513;
      4'd11:   v = 28'd217739269;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/midi_track_event_parser_unit.sv
// MIDI track parser: one track byte per input beat, at most one event beat out.
// Each byte is latched, then handled by one sequencer step; a new byte is not taken
// until that step is done. A tempo event runs the bit-serial 60000000/m divider
// before its beat appears. Input is held off while the division runs or a result
// beat waits.
module midi_track_event_parser_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_track_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_kind,
  output logic [3:0]        out_channel,
  output logic [27:0]       out_delta_ticks,
  output logic [7:0]        out_note_number,
  output logic [7:0]        out_velocity,
  output logic [17:0]       out_note_freq,
  output logic [25:0]       out_tempo_bpm,
  output logic signed [7:0] out_key_accidentals,
  output logic [7:0]        out_key_mode,
  output logic [31:0]       out_time_sig_word
);
  mtp_pkg::dp_cmd_t cmd;
  mtp_pkg::dp_sts_t sts;
  logic [3:0]       kind_sel;

  mtp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .kind_sel(kind_sel), .sts(sts)
  );

  mtp_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_byte(in_track_byte), .cmd(cmd), .kind_sel(kind_sel),
    .sts(sts), .out_kind(out_kind), .out_channel(out_channel),
    .out_delta_ticks(out_delta_ticks), .out_note_number(out_note_number),
    .out_velocity(out_velocity), .out_note_freq(out_note_freq),
    .out_tempo_bpm(out_tempo_bpm), .out_key_accidentals(out_key_accidentals),
    .out_key_mode(out_key_mode), .out_time_sig_word(out_time_sig_word)
  );
endmodule

FILE: hw/rtl/mtp_divider.sv
// Restoring divider: 60000000 / m, one quotient bit per cycle
module mtp_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] divisor,
  output logic        busy,
  output logic [25:0] quotient
);
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [25:0] q_r, q_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [23:0] d_r, d_nxt;
  logic [24:0] trial;

  assign busy     = busy_r;
  assign quotient = q_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    trial    = {rem_r[23:0], mtp_pkg::TEMPO_NUM[cnt_r]};
    if (start) begin
      d_nxt    = divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = 5'd25;
      busy_nxt = (divisor != 24'd0);
    end else if (busy_r) begin
      // shift in one dividend bit, subtract if it fits
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[24:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[24:0], 1'b0};
      end
      if (cnt_r == 5'd0) busy_nxt = 1'b0;
      else cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end
endmodule

FILE: hw/rtl/mtp_datapath.sv
// Byte registers, accumulators and result fields
module mtp_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_byte,
  input  mtp_pkg::dp_cmd_t     cmd,
  input  logic [3:0]           kind_sel,
  output mtp_pkg::dp_sts_t     sts,
  output logic [3:0]           out_kind,
  output logic [3:0]           out_channel,
  output logic [27:0]          out_delta_ticks,
  output logic [7:0]           out_note_number,
  output logic [7:0]           out_velocity,
  output logic [17:0]          out_note_freq,
  output logic [25:0]          out_tempo_bpm,
  output logic signed [7:0]    out_key_accidentals,
  output logic [7:0]           out_key_mode,
  output logic [31:0]          out_time_sig_word
);
  logic [7:0]  byte_r;
  logic [31:0] hdr_r, hdr_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [27:0] cnt_r, cnt_nxt;
  logic [27:0] vlq_r, vlq_nxt;
  logic [27:0] delta_r, delta_nxt;
  logic [7:0]  stat_r, stat_nxt;
  logic [7:0]  mtype_r, mtype_nxt;
  logic [31:0] data_r, data_nxt;
  logic [27:0] vlq_sh;
  logic [3:0]  kind_r;
  logic [17:0] freq_r;
  logic        div_busy;
  logic [25:0] quot;
  logic [8:0]  np3;
  logic [16:0] oct_prod;
  logic [3:0]  oct;
  logic [3:0]  rem12;
  logic [27:0] ftab;
  logic [27:0] fsum;

  mtp_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .divisor(data_r[23:0]), .busy(div_busy), .quotient(quot)
  );

  assign vlq_sh = {vlq_r[20:0], byte_r[6:0]};

  always_comb begin
    hdr_nxt   = hdr_r;
    hcnt_nxt  = hcnt_r;
    cnt_nxt   = cnt_r;
    vlq_nxt   = vlq_r;
    delta_nxt = delta_r;
    stat_nxt  = stat_r;
    mtype_nxt = mtype_r;
    data_nxt  = data_r;
    unique case (cmd.op)
      mtp_pkg::OP_HDR: begin
        if (!hcnt_r[2]) hdr_nxt = {hdr_r[23:0], byte_r};
        hcnt_nxt = hcnt_r + 3'd1;
        vlq_nxt  = '0;
      end
      mtp_pkg::OP_DELTA: begin
        if (byte_r[7]) vlq_nxt = vlq_sh;
        else begin
          delta_nxt = vlq_sh;
          vlq_nxt   = '0;
        end
      end
      mtp_pkg::OP_STATUS: begin
        stat_nxt = byte_r;
        data_nxt = '0;
        cnt_nxt  = (byte_r[7:4] == 4'hC || byte_r[7:4] == 4'hD) ? 28'd1 : 28'd2;
      end
      mtp_pkg::OP_DATA: begin
        data_nxt = {data_r[23:0], byte_r};
        if (cnt_r != '0) cnt_nxt = cnt_r - 28'd1;
      end
      mtp_pkg::OP_SKIP: begin
        if (cnt_r != '0) cnt_nxt = cnt_r - 28'd1;
      end
      mtp_pkg::OP_MTYPE: begin
        mtype_nxt = byte_r;
        vlq_nxt   = '0;
      end
      mtp_pkg::OP_MLEN: begin
        data_nxt = '0;
        cnt_nxt  = (mtype_r == mtp_pkg::META_TEMPO) ? 28'd3 :
                   (mtype_r == mtp_pkg::META_TSIG) ? 28'd4 : 28'd2;
      end
      mtp_pkg::OP_SKLEN: begin
        if (byte_r[7]) vlq_nxt = vlq_sh;
        else begin
          cnt_nxt = vlq_sh;
          vlq_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  // note frequency: the note number sits in the low data byte at the emit step
  always_comb begin
    np3      = {1'b0, data_r[7:0]} + 9'd3;
    // divide by 12 through a reciprocal multiply (exact for this range)
    oct_prod = 17'(np3) * 17'd171;
    oct      = oct_prod[14:11];
    rem12    = 4'(np3 - 9'(oct) * 9'd12);
    ftab     = mtp_pkg::freq_tab(rem12);
    fsum     = ftab + (28'd1 << (5'd19 - {1'b0, oct}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r  <= '0;
      hdr_r   <= '0;
      cnt_r   <= '0;
      vlq_r   <= '0;
      delta_r <= '0;
      stat_r  <= '0;
      mtype_r <= '0;
      data_r  <= '0;
    end else begin
      hcnt_r  <= hcnt_nxt;
      hdr_r   <= hdr_nxt;
      cnt_r   <= cnt_nxt;
      vlq_r   <= vlq_nxt;
      delta_r <= delta_nxt;
      stat_r  <= stat_nxt;
      mtype_r <= mtype_nxt;
      data_r  <= data_nxt;
    end
    if (cmd.load) byte_r <= in_byte;
    if (cmd.emit) begin
      kind_r <= kind_sel;
      freq_r <= data_r[7] ? mtp_pkg::FREQ_MAX : 18'(fsum >> (5'd20 - {1'b0, oct}));
    end
  end

  assign sts.byte_v    = byte_r;
  assign sts.hdr_cnt   = hcnt_r;
  assign sts.tag_ok    = (hdr_r == mtp_pkg::MTRK_TAG);
  assign sts.count     = cnt_r;
  assign sts.status    = stat_r;
  assign sts.mtype     = mtype_r;
  assign sts.div_busy  = div_busy;
  assign sts.skip_zero = (vlq_sh == 28'd0);

  // shape the result beat from the held fields
  always_comb begin
    out_kind            = kind_r;
    out_delta_ticks     = (kind_r == mtp_pkg::K_BAD_HEADER) ? 28'd0 : delta_r;
    out_channel         = 4'd0;
    out_note_number     = 8'd0;
    out_velocity        = 8'd0;
    out_note_freq       = 18'd0;
    out_tempo_bpm       = 26'd0;
    out_key_accidentals = 8'sd0;
    out_key_mode        = 8'd0;
    out_time_sig_word   = 32'd0;
    if (kind_r == mtp_pkg::K_NOTE_OFF || kind_r == mtp_pkg::K_NOTE_ON) begin
      out_channel     = stat_r[3:0];
      out_note_number = data_r[15:8];
      out_velocity    = data_r[7:0];
      out_note_freq   = freq_r;
    end
    if (kind_r == mtp_pkg::K_TEMPO) out_tempo_bpm = quot;
    if (kind_r == mtp_pkg::K_KEY) begin
      out_key_accidentals = signed'(data_r[15:8]);
      out_key_mode        = data_r[7:0];
    end
    if (kind_r == mtp_pkg::K_TIME_SIG) out_time_sig_word = data_r;
  end
endmodule

FILE: hw/rtl/mtp_ctrl.sv
`include "assert_macros.svh"
// Parser sequencer: takes a byte, runs one datapath step, emits a result beat when an event completes
module mtp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output mtp_pkg::dp_cmd_t cmd,
  output logic [3:0]       kind_sel,
  input  mtp_pkg::dp_sts_t sts
);
  typedef enum logic [3:0] {
    S_HEADER, S_DELTA, S_STATUS, S_NOTE, S_SKIP, S_MTYPE, S_MLEN, S_MDATA, S_SKLEN
  } ph_t;

  ph_t         ph_r, ph_nxt;
  logic        busy_r, busy_nxt;   // byte latched, step pending
  logic        wait_r, wait_nxt;   // tempo division running
  logic        halt_r, halt_nxt;
  logic        ov_r, ov_nxt;
  logic        waitdly_r;
  logic [7:0]  b;
  logic        accept;

  assign b         = sts.byte_v;
  assign in_ready  = !busy_r && !wait_r && !ov_r;
  assign out_valid = ov_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    ph_nxt        = ph_r;
    busy_nxt      = accept;
    wait_nxt      = wait_r;
    halt_nxt      = halt_r;
    ov_nxt        = ov_r && !out_ready;
    cmd.load      = accept;
    cmd.op        = mtp_pkg::OP_NONE;
    // launch the division once the tempo word has settled
    cmd.div_start = wait_r && !waitdly_r;
    cmd.emit      = 1'b0;
    kind_sel      = mtp_pkg::K_NOTE_OFF;
    if (wait_r && waitdly_r && !sts.div_busy) begin
      wait_nxt = 1'b0;
      ov_nxt   = 1'b1;
      cmd.emit = 1'b1;
      kind_sel = mtp_pkg::K_TEMPO;
    end
    if (busy_r && !halt_r) begin
      unique case (ph_r)
        S_HEADER: begin
          cmd.op = mtp_pkg::OP_HDR;
          if (sts.hdr_cnt == 3'd7) begin
            if (sts.tag_ok) ph_nxt = S_DELTA;
            else begin
              halt_nxt = 1'b1;
              cmd.emit = 1'b1;
              kind_sel = mtp_pkg::K_BAD_HEADER;
            end
          end
        end
        S_DELTA: begin
          cmd.op = mtp_pkg::OP_DELTA;
          if (!b[7]) ph_nxt = S_STATUS;
        end
        S_STATUS: begin
          cmd.op = mtp_pkg::OP_STATUS;
          if (b == 8'hFF) ph_nxt = S_MTYPE;
          else if (b >= 8'hF0) begin
            ph_nxt   = S_DELTA;
            cmd.emit = 1'b1;
            kind_sel = mtp_pkg::K_SYSEX;
          end else if (!b[7]) begin
            halt_nxt = 1'b1;
            cmd.emit = 1'b1;
            kind_sel = mtp_pkg::K_BAD_STATUS;
          end else if (b[7:4] == 4'h8 || b[7:4] == 4'h9) ph_nxt = S_NOTE;
          else ph_nxt = S_SKIP;
        end
        S_NOTE: begin
          cmd.op = mtp_pkg::OP_DATA;
          if (sts.count <= 28'd1) begin
            ph_nxt   = S_DELTA;
            cmd.emit = 1'b1;
            kind_sel = (sts.status[7:4] == 4'h9) ? mtp_pkg::K_NOTE_ON : mtp_pkg::K_NOTE_OFF;
          end
        end
        S_SKIP: begin
          cmd.op = mtp_pkg::OP_SKIP;
          if (sts.count <= 28'd1) ph_nxt = S_DELTA;
        end
        S_MTYPE: begin
          cmd.op = mtp_pkg::OP_MTYPE;
          if (b == mtp_pkg::META_END || b == mtp_pkg::META_TEMPO ||
              b == mtp_pkg::META_TSIG || b == mtp_pkg::META_KEY) ph_nxt = S_MLEN;
          else begin
            ph_nxt = S_SKLEN;
            if (!(b <= 8'h07 || b == 8'h20 || b == 8'h54 || b == 8'h7F)) begin
              cmd.emit = 1'b1;
              kind_sel = mtp_pkg::K_UNKNOWN_META;
            end
          end
        end
        S_MLEN: begin
          if (sts.mtype == mtp_pkg::META_END) begin
            halt_nxt = 1'b1;
            cmd.emit = 1'b1;
            kind_sel = mtp_pkg::K_END;
          end else begin
            cmd.op = mtp_pkg::OP_MLEN;
            ph_nxt = S_MDATA;
          end
        end
        S_MDATA: begin
          cmd.op = mtp_pkg::OP_DATA;
          if (sts.count <= 28'd1) begin
            ph_nxt = S_DELTA;
            if (sts.mtype == mtp_pkg::META_TEMPO) wait_nxt = 1'b1;
            else begin
              cmd.emit = 1'b1;
              kind_sel = (sts.mtype == mtp_pkg::META_TSIG) ? mtp_pkg::K_TIME_SIG
                                                            : mtp_pkg::K_KEY;
            end
          end
        end
        S_SKLEN: begin
          cmd.op = mtp_pkg::OP_SKLEN;
          // zero length returns to delta, otherwise skip the body
          if (!b[7]) ph_nxt = sts.skip_zero ? S_DELTA : S_SKIP;
        end
        default: ;
      endcase
      if (cmd.emit) ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= S_HEADER;
      busy_r    <= 1'b0;
      wait_r    <= 1'b0;
      halt_r    <= 1'b0;
      ov_r      <= 1'b0;
      waitdly_r <= 1'b0;
    end else begin
      ph_r      <= ph_nxt;
      busy_r    <= busy_nxt;
      wait_r    <= wait_nxt;
      halt_r    <= halt_nxt;
      ov_r      <= ov_nxt;
      waitdly_r <= wait_r && !(waitdly_r && !sts.div_busy);
    end
  end

  `CHK_IMPL(a_no_accept_busy, clk, rst_n, busy_r || wait_r, !in_ready, "accept while busy")
  `CHK_NEXT(a_halt_sticky, clk, rst_n, halt_r, halt_r, "halt cleared")
  `CHK_IMPL(a_emit_free, clk, rst_n, cmd.emit, !ov_r, "emit over pending beat")
endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef enum logic [3:0] {
    ST_HEADER, ST_DELTA, ST_STATUS, ST_NOTE, ST_SKIP,
    ST_META_TYPE, ST_META_LEN, ST_META_DATA, ST_SKIP_LEN
  } parse_state_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  channel;
    logic [27:0] delta_ticks;
    logic [7:0]  note_number;
    logic [7:0]  velocity;
    logic [17:0] note_freq;
    logic [25:0] tempo_bpm;
    logic [7:0]  key_accidentals;
    logic [7:0]  key_mode;
    logic [31:0] time_sig_word;
  } midi_event_t;

  localparam logic [7:0] META_SEQ_NAME = 8'h03;
  localparam logic [7:0] META_SEQ_SPEC = 8'h7F;
  localparam logic [7:0] META_ODD      = 8'h08;
  localparam int IDLE_LIMIT = 6000;
  localparam int STREAM_BYTES = 1650;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_track_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_kind;
  logic [3:0] out_channel;
  logic [27:0] out_delta_ticks;
  logic [7:0] out_note_number;
  logic [7:0] out_velocity;
  logic [17:0] out_note_freq;
  logic [25:0] out_tempo_bpm;
  logic signed [7:0] out_key_accidentals;
  logic [7:0] out_key_mode;
  logic [31:0] out_time_sig_word;

  midi_track_event_parser_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] track_bytes[$];
  midi_event_t expected_events[$];
  int mismatches = 0;
  int cycle_no = 0;
  int idle_cycles = 0;
  logic in_taken = 1'b0;

  // parser state mirror
  parse_state_t pstate = ST_HEADER;
  logic [31:0] hdr_word = '0;
  logic [27:0] bcount = '0;
  logic [27:0] vlq = '0;
  logic [27:0] delta_hold = '0;
  logic [7:0] status_hold = '0;
  logic [7:0] meta_hold = '0;
  logic [31:0] data_word = '0;
  logic stopped = 1'b0;

  logic [31:0] pitch_tab[12] = '{
    32'd115343360, 32'd122202033, 32'd129468544, 32'd137167144,
    32'd145323527, 32'd153964914, 32'd163120144, 32'd172819773,
    32'd183096171, 32'd193983646, 32'd205518513, 32'd217739269};

  function automatic logic [17:0] pitch_of(input logic [7:0] n);
    int o, r, sh;
    if (n > 8'd127) return 18'd200702;
    o = (int'(n) + 3) / 12;
    r = (int'(n) + 3) % 12;
    sh = 20 - o;
    return 18'((pitch_tab[r] + (32'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic midi_event_t bare_event(input logic [3:0] k, input logic [27:0] d);
    midi_event_t e;
    e = '0;
    e.kind = k;
    e.delta_ticks = d;
    return e;
  endfunction

  // advance the parser mirror by one byte, queue any event it yields
  task automatic parse_byte(input logic [7:0] b);
    midi_event_t e;
    logic [23:0] m;
    if (stopped) return;
    case (pstate)
      ST_HEADER: begin
        if (bcount < 4) hdr_word = {hdr_word[23:0], b};
        bcount = bcount + 1;
        if (bcount == 8) begin
          bcount = 0;
          vlq = 0;
          if (hdr_word != mtp_pkg::MTRK_TAG) begin
            stopped = 1'b1;
            expected_events.push_back(bare_event(mtp_pkg::K_BAD_HEADER, 28'd0));
          end else pstate = ST_DELTA;
        end
      end
      ST_DELTA: begin
        vlq = {vlq[20:0], b[6:0]};
        if (!b[7]) begin
          delta_hold = vlq;
          vlq = 0;
          pstate = ST_STATUS;
        end
      end
      ST_STATUS: begin
        status_hold = b;
        if (b == 8'hFF) pstate = ST_META_TYPE;
        else if (b >= 8'hF0) begin
          pstate = ST_DELTA;
          expected_events.push_back(bare_event(mtp_pkg::K_SYSEX, delta_hold));
        end else if (b < 8'h80) begin
          stopped = 1'b1;
          expected_events.push_back(bare_event(mtp_pkg::K_BAD_STATUS, delta_hold));
        end else begin
          data_word = 0;
          if (b[7:4] == 4'h8 || b[7:4] == 4'h9) begin
            bcount = 2;
            pstate = ST_NOTE;
          end else begin
            bcount = (b[7:4] == 4'hC || b[7:4] == 4'hD) ? 1 : 2;
            pstate = ST_SKIP;
          end
        end
      end
      ST_NOTE: begin
        data_word = {data_word[23:0], b};
        if (bcount > 0) bcount = bcount - 1;
        if (bcount == 0) begin
          pstate = ST_DELTA;
          e = bare_event(status_hold[7:4] == 4'h9 ? mtp_pkg::K_NOTE_ON
                                                   : mtp_pkg::K_NOTE_OFF, delta_hold);
          e.channel = status_hold[3:0];
          e.note_number = data_word[15:8];
          e.velocity = data_word[7:0];
          e.note_freq = pitch_of(data_word[15:8]);
          expected_events.push_back(e);
        end
      end
      ST_SKIP: begin
        if (bcount > 0) bcount = bcount - 1;
        if (bcount == 0) pstate = ST_DELTA;
      end
      ST_META_TYPE: begin
        meta_hold = b;
        if (b == mtp_pkg::META_END || b == mtp_pkg::META_TEMPO ||
            b == mtp_pkg::META_TSIG || b == mtp_pkg::META_KEY)
          pstate = ST_META_LEN;
        else begin
          vlq = 0;
          pstate = ST_SKIP_LEN;
          if (!(b <= 8'h07 || b == 8'h20 || b == 8'h54 || b == 8'h7F))
            expected_events.push_back(bare_event(mtp_pkg::K_UNKNOWN_META, delta_hold));
        end
      end
      ST_META_LEN: begin
        if (meta_hold == mtp_pkg::META_END) begin
          stopped = 1'b1;
          expected_events.push_back(bare_event(mtp_pkg::K_END, delta_hold));
        end else begin
          data_word = 0;
          bcount = (meta_hold == mtp_pkg::META_TEMPO) ? 3 :
                   (meta_hold == mtp_pkg::META_TSIG) ? 4 : 2;
          pstate = ST_META_DATA;
        end
      end
      ST_META_DATA: begin
        data_word = {data_word[23:0], b};
        if (bcount > 0) bcount = bcount - 1;
        if (bcount == 0) begin
          pstate = ST_DELTA;
          if (meta_hold == mtp_pkg::META_TEMPO) begin
            m = data_word[23:0];
            e = bare_event(mtp_pkg::K_TEMPO, delta_hold);
            e.tempo_bpm = (m != 0) ? 26'(32'd60000000 / m) : 26'd0;
          end else if (meta_hold == mtp_pkg::META_TSIG) begin
            e = bare_event(mtp_pkg::K_TIME_SIG, delta_hold);
            e.time_sig_word = data_word;
          end else begin
            e = bare_event(mtp_pkg::K_KEY, delta_hold);
            e.key_accidentals = data_word[15:8];
            e.key_mode = data_word[7:0];
          end
          expected_events.push_back(e);
        end
      end
      ST_SKIP_LEN: begin
        vlq = {vlq[20:0], b[6:0]};
        if (!b[7]) begin
          bcount = vlq;
          vlq = 0;
          pstate = (bcount == 0) ? ST_DELTA : ST_SKIP;
        end
      end
      default: ;
    endcase
  endtask

  // stimulus builders
  task automatic put_vlq(input logic [27:0] v, input int extra);
    int n;
    n = 1;
    while (n < 4 && (v >> (7 * n)) != 0) n++;
    // extra leading continuation bytes, with random payload, lengthen the quantity
    repeat (extra) track_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
    for (int i = n - 1; i >= 0; i--)
      track_bytes.push_back({i != 0, 7'(v >> (7 * i))});
  endtask

  task automatic put_bytes(input int n);
    repeat (n) track_bytes.push_back(8'($urandom));
  endtask

  task automatic put_meta(input logic [7:0] mt, input int n);
    track_bytes.push_back(8'hFF);
    track_bytes.push_back(mt);
    track_bytes.push_back(8'($urandom));
    put_bytes(n);
  endtask

  task automatic put_random_event();
    int pick;
    int hi;
    logic [27:0] d;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: d = 28'($urandom);
      1, 2: d = 28'($urandom_range(0, 16383));
      default: d = 28'($urandom_range(0, 127));
    endcase
    put_vlq(d, ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0);
    if (pick < 40) begin
      track_bytes.push_back({$urandom_range(0, 1) ? 4'h9 : 4'h8, 4'($urandom)});
      put_bytes(2);
    end else if (pick < 50) begin
      // program change and channel pressure carry one data byte
      hi = $urandom_range(10, 14);
      track_bytes.push_back({4'(hi), 4'($urandom)});
      put_bytes((hi == 12 || hi == 13) ? 1 : 2);
    end else if (pick < 58) begin
      put_meta(mtp_pkg::META_TEMPO, 0);
      case ($urandom_range(0, 5))
        0: repeat (3) track_bytes.push_back(8'h00);
        default: put_bytes(3);
      endcase
    end else if (pick < 66) put_meta(mtp_pkg::META_KEY, 2);
    else if (pick < 74) put_meta(mtp_pkg::META_TSIG, 4);
    else if (pick < 82) track_bytes.push_back(8'($urandom_range(8'hF0, 8'hFE)));
    else begin
      track_bytes.push_back(8'hFF);
      track_bytes.push_back(8'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 7)));
      if (track_bytes[$] == mtp_pkg::META_END || track_bytes[$] == mtp_pkg::META_TEMPO ||
          track_bytes[$] == mtp_pkg::META_TSIG || track_bytes[$] == mtp_pkg::META_KEY)
        track_bytes[$] = META_SEQ_NAME;
      pick = $urandom_range(0, 6);
      put_vlq(28'(pick), 0);
      put_bytes(pick);
    end
  endtask

  initial begin
    // header tag and ignored length
    track_bytes = '{8'h4D, 8'h54, 8'h72, 8'h6B};
    put_bytes(4);
    // zero-velocity note-on, highest note, top legal note
    put_vlq(28'd0, 0);
    track_bytes.push_back(8'h90);
    track_bytes.push_back(8'h00);
    track_bytes.push_back(8'h00);
    put_vlq(28'h0FFFFFFF, 0);
    track_bytes.push_back(8'h8F);
    track_bytes.push_back(8'hFF);
    track_bytes.push_back(8'hFF);
    put_vlq(28'd5, 2);
    track_bytes.push_back(8'h9A);
    track_bytes.push_back(8'd127);
    track_bytes.push_back(8'h40);
    // tempo with zero, unit and full divisors
    put_vlq(28'd1, 0);
    put_meta(mtp_pkg::META_TEMPO, 0);
    put_vlq(28'd0, 0); track_bytes.push_back(8'h00); track_bytes.push_back(8'h00);
    put_vlq(28'd0, 0);
    put_meta(mtp_pkg::META_TEMPO, 0);
    track_bytes.push_back(8'h00); track_bytes.push_back(8'h00); track_bytes.push_back(8'h01);
    put_vlq(28'd0, 0);
    put_meta(mtp_pkg::META_TEMPO, 0);
    track_bytes.push_back(8'hFF); track_bytes.push_back(8'hFF); track_bytes.push_back(8'hFF);
    // key extremes, full time signature
    put_vlq(28'd0, 0);
    put_meta(mtp_pkg::META_KEY, 0);
    track_bytes.push_back(8'h80); track_bytes.push_back(8'hFF);
    put_vlq(28'd0, 0);
    put_meta(mtp_pkg::META_TSIG, 0);
    put_bytes(0);
    repeat (4) track_bytes.push_back(8'hFF);
    // sysex both ends, unknown meta, skipped meta
    put_vlq(28'd0, 0); track_bytes.push_back(8'hF0);
    put_vlq(28'd0, 0); track_bytes.push_back(8'hFE);
    put_vlq(28'd0, 0); track_bytes.push_back(8'hFF); track_bytes.push_back(META_ODD);
    put_vlq(28'd0, 0);
    put_vlq(28'd0, 0); track_bytes.push_back(8'hFF); track_bytes.push_back(META_SEQ_SPEC);
    put_vlq(28'd2, 0); put_bytes(2);
    // random body
    while (track_bytes.size() < STREAM_BYTES) put_random_event();
    // end of track, then bytes that must be ignored
    put_vlq(28'($urandom_range(0, 200)), 0);
    put_meta(mtp_pkg::META_END, 0);
    put_bytes(6);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    forever begin
      @(posedge clk);
      if (track_bytes.size() == 0 && !in_valid && expected_events.size() == 0) break;
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  // sample both channels and check results in order
  always @(posedge clk) begin
    midi_event_t got, want;
    cycle_no <= cycle_no + 1;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) parse_byte(in_track_byte);
      if (out_valid && out_ready) begin
        got = '{out_kind, out_channel, out_delta_ticks, out_note_number, out_velocity,
                out_note_freq, out_tempo_bpm, out_key_accidentals, out_key_mode,
                out_time_sig_word};
        if (expected_events.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected event beat %p", got);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("event mismatch: exp %p got %p", want, got);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // sender: bursts of beats with gaps
  int burst_left = 8;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (track_bytes.size() > 0) begin
        in_valid <= 1'b1;
        in_track_byte <= track_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 60);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else burst_left <= burst_left - 1;
      end else in_valid <= 1'b0;
    end
  end

  // receiver: stall pattern rotates through always ready, random and mostly stalled, with one long hold-off
  always @(negedge clk) begin
    if (cycle_no >= 1500 && cycle_no < 2300) out_ready <= 1'b0;
    else case ((cycle_no / 64) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

endmodule
